// ===== design/tfs_pkg.sv =====
`timescale 1ns / 1ps

package tfs_pkg;

    localparam int COORDS      = 6;   // near x, y, z then far x, y, z
    localparam int COORD_W     = 24;
    localparam int COORD_SEL_W = 3;
    localparam int BLEND_W     = 17;
    localparam int IDX_W       = 5;
    localparam int PROD_W      = COORD_W + 1 + BLEND_W + 1;
    localparam int FRAC_W      = 16;
    localparam int S_TDATA_W   = COORDS * COORD_W;
    localparam int M_TDATA_W   = 152; // index plus six coordinates, padded to bytes

    localparam logic [BLEND_W-1:0]     BLEND_ONE   = 17'h10000;
    localparam logic [BLEND_W-1:0]     BLEND_RESET = 17'h02000;
    localparam logic [COORD_SEL_W-1:0] LAST_COORD  = 3'd5;

    typedef logic signed [COORD_W-1:0] coord_t;

endpackage

// ===== design/trail_follow_smoother.sv =====
`timescale 1ns / 1ps

// Trail follow smoother: a chain of SEGMENTS+1 vertex pairs, each coordinate a
// first-order low-pass follower of the node before it (node 0 follows the head).
//   s_*   : one transfer per tick, six signed Q16.8 head coordinates.
//   m_*   : SEGMENTS+1 transfers per tick, one per node in index order;
//           tlast marks the final node of the tick.
//   cfg_* : blend weight, Q1.16, written whenever cfg_we is high; values above
//           1.0 are clamped to 1.0. Write only while the block is idle.
// Timing: the vertex store is one single-port-read RAM, one coordinate read per
// cycle through a three-stage read / subtract / multiply / write-back pipe.
// Each node issues its six coordinate reads, then drains the pipe before its
// result is registered for output; the nodes of a tick run one after another.
// Reset: every vertex reads as zero (per-node valid flags, no clearing pass),
// blend returns to 8192 (0.125). A tick can be taken as soon as reset is
// released.
// Stall: a result holds in the output register; the next node does not start
// until it has been taken, and no new tick is accepted until the last has gone.

module trail_follow_smoother
    import tfs_pkg::*;
#(
    parameter int SEGMENTS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // fields from bit 0: head_start_x, head_start_y, head_start_z,
    //                    head_end_x, head_end_y, head_end_z
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // fields from bit 0: node_index, near_x, near_y, near_z, far_x, far_y, far_z
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast,  // is_last
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic                 cfg_we,
    input  logic [BLEND_W-1:0]   cfg_wdata
);

    localparam int NODES  = SEGMENTS + 1;
    localparam int NODE_W = $clog2(NODES);
    localparam int DEPTH  = NODES * COORDS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(SEGMENTS);

    typedef enum logic [1:0] {
        IDLE,
        ISSUE,
        DRAIN,
        WAIT_OUT
    } state_t;

    // control
    state_t                 state_reg, state_next;
    logic [NODE_W-1:0]      node_reg, node_next;
    logic [COORD_SEL_W-1:0] coord_reg, coord_next;
    logic [NODES-1:0]       node_valid_reg, node_valid_next;
    logic                   out_valid_reg, out_valid_next;
    logic [BLEND_W-1:0]     blend_reg, blend_next;
    logic                   a_vld_reg, b_vld_reg, c_vld_reg;

    // pipe payload
    logic [COORD_SEL_W-1:0] a_coord_reg, b_coord_reg, c_coord_reg;
    logic [ADDR_W-1:0]      a_addr_reg, b_addr_reg, c_addr_reg;
    logic                   a_init_reg;
    coord_t                 b_old_reg, c_old_reg;
    logic signed [COORD_W:0] b_diff_reg;
    logic signed [PROD_W-1:0] c_prod_reg;

    coord_t                 dest_reg [COORDS];
    coord_t                 out_coord_reg [COORDS];
    logic [IDX_W-1:0]       out_index_reg;
    logic                   out_last_reg;

    logic                   s_fire, m_fire, issue, wb_last;
    logic [ADDR_W-1:0]      rd_addr;
    logic [COORD_W-1:0]     rd_data;
    coord_t                 a_old;
    logic signed [COORD_W:0] diff_next;
    logic signed [BLEND_W:0] blend_s;
    logic signed [PROD_W-1:0] prod_next;
    coord_t                 wb_value;

    assign s_tready = (state_reg == IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign m_fire   = out_valid_reg && m_tready;
    assign issue    = (state_reg == ISSUE);
    assign wb_last  = c_vld_reg && (c_coord_reg == LAST_COORD);

    assign rd_addr = ADDR_W'(ADDR_W'(node_reg) * ADDR_W'(COORDS) + ADDR_W'(coord_reg));

    tfs_ram #(
        .WIDTH (COORD_W),
        .DEPTH (DEPTH)
    ) u_vertex_ram (
        .clk   (clk),
        .we    (c_vld_reg),
        .waddr (c_addr_reg),
        .wdata (wb_value),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // arithmetic: never-written nodes read as zero
    assign a_old     = a_init_reg ? coord_t'(rd_data) : '0;
    assign diff_next = (COORD_W+1)'(dest_reg[a_coord_reg]) - (COORD_W+1)'(a_old);
    assign blend_s   = signed'({1'b0, blend_reg});
    assign prod_next = b_diff_reg * blend_s;
    // floor((dest - old) * blend / 2^16), kept to 24 bits
    assign wb_value  = c_old_reg + coord_t'(c_prod_reg[FRAC_W +: COORD_W]);

    always_comb
    begin
        state_next      = state_reg;
        node_next       = node_reg;
        coord_next      = coord_reg;
        node_valid_next = node_valid_reg;
        out_valid_next  = out_valid_reg;
        blend_next      = blend_reg;

        if (cfg_we)
        begin
            blend_next = (cfg_wdata > BLEND_ONE) ? BLEND_ONE : cfg_wdata;
        end

        if (wb_last)
        begin
            node_valid_next[node_reg] = 1'b1;
        end

        if (m_fire)
        begin
            out_valid_next = 1'b0;
        end
        if (wb_last)
        begin
            out_valid_next = 1'b1;
        end

        unique case (state_reg)
            IDLE:
            begin
                if (s_fire)
                begin
                    node_next  = '0;
                    coord_next = '0;
                    state_next = ISSUE;
                end
            end
            ISSUE:
            begin
                coord_next = coord_reg + 1'b1;
                if (coord_reg == LAST_COORD)
                begin
                    state_next = DRAIN;
                end
            end
            DRAIN:
            begin
                if (wb_last)
                begin
                    state_next = WAIT_OUT;
                end
            end
            WAIT_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    coord_next = '0;
                    if (node_reg == LAST_NODE)
                    begin
                        state_next = IDLE;
                    end
                    else
                    begin
                        node_next  = node_reg + 1'b1;
                        state_next = ISSUE;
                    end
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= IDLE;
            node_reg       <= '0;
            coord_reg      <= '0;
            node_valid_reg <= '0;
            out_valid_reg  <= 1'b0;
            blend_reg      <= BLEND_RESET;
            a_vld_reg      <= 1'b0;
            b_vld_reg      <= 1'b0;
            c_vld_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            node_reg       <= node_next;
            coord_reg      <= coord_next;
            node_valid_reg <= node_valid_next;
            out_valid_reg  <= out_valid_next;
            blend_reg      <= blend_next;
            a_vld_reg      <= issue;
            b_vld_reg      <= a_vld_reg;
            c_vld_reg      <= b_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        // stage a: RAM read in flight
        a_coord_reg <= coord_reg;
        a_addr_reg  <= rd_addr;
        a_init_reg  <= node_valid_reg[node_reg];
        // stage b: difference
        b_coord_reg <= a_coord_reg;
        b_addr_reg  <= a_addr_reg;
        b_old_reg   <= a_old;
        b_diff_reg  <= diff_next;
        // stage c: product
        c_coord_reg <= b_coord_reg;
        c_addr_reg  <= b_addr_reg;
        c_old_reg   <= b_old_reg;
        c_prod_reg  <= prod_next;

        if (s_fire)
        begin
            for (int i = 0; i < COORDS; i++)
            begin
                dest_reg[i] <= coord_t'(s_tdata[i*COORD_W +: COORD_W]);
            end
        end
        else if (c_vld_reg)
        begin
            // this node's result is the next node's target
            dest_reg[c_coord_reg] <= wb_value;
        end

        if (c_vld_reg)
        begin
            out_coord_reg[c_coord_reg] <= wb_value;
        end
        if (wb_last)
        begin
            out_index_reg <= IDX_W'(node_reg);
            out_last_reg  <= (node_reg == LAST_NODE);
        end
    end

    always_comb
    begin
        m_tdata = '0;
        m_tdata[IDX_W-1:0] = out_index_reg;
        for (int i = 0; i < COORDS; i++)
        begin
            m_tdata[IDX_W + i*COORD_W +: COORD_W] = out_coord_reg[i];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;

`ifndef SYNTHESIS
    a_no_accept_with_pending: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire |-> !out_valid_reg)
        else $error("tick accepted while a result is pending");

    a_wb_inside_tick: assert property (@(posedge clk) disable iff (!rst_n)
        c_vld_reg |-> (state_reg == ISSUE || state_reg == DRAIN))
        else $error("write-back outside a node pass");

    a_out_from_last_coord: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(wb_last))
        else $error("result raised without final coordinate write-back");

    a_last_at_final_node: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_last_reg) |-> (node_reg == LAST_NODE))
        else $error("last mark on a node other than the final one");
`endif

endmodule

// ===== design/tfs_ram.sv =====
`timescale 1ns / 1ps

module tfs_ram #(
    parameter int WIDTH  = 24,
    parameter int DEPTH  = 102,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

// Testbench for trail_follow_smoother.
// Each head tick sent on the slave stream is run through a behavioural copy of
// the follower chain here. That copy holds its own vertex store and blend
// weight. The SEGMENTS+1 node results it predicts are queued, and every
// master-side transfer is checked field by field against the oldest entry.
// The directed tests come first: the reset weight, full-scale coordinates,
// clamping of the weight, a zero weight and floor rounding. A long receiver
// hold-off then makes the block stall its input. The random phases follow,
// with sender and receiver idling in turn. The blend weight is only rewritten
// once every expected result has arrived.

module tb;
    import tfs_pkg::*;

    localparam int SEGMENTS      = 16;
    localparam int NODES         = SEGMENTS + 1;
    localparam int SETTLE_CYCLES = 12;     // settle time after the last expected result
    localparam int HOLD_CYCLES   = 400;    // receiver hold-off, long enough to fill the block
    localparam int PRINT_CAP     = 60;

    typedef coord_t coord_set_t [COORDS];

    typedef struct {
        logic [IDX_W-1:0] node_index;
        coord_t           coord [COORDS];
        logic             is_last;
    } node_result_t;

    // ---------------------------------------------------------------------
    // DUT signals; the inputs driven here are known from time zero
    // ---------------------------------------------------------------------
    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [BLEND_W-1:0]   cfg_wdata = '0;

    // ---------------------------------------------------------------------
    // Predictor state: trail vertices and blend weight as the block should
    // hold them
    // ---------------------------------------------------------------------
    coord_t             trail_pos [NODES][COORDS];
    logic [BLEND_W-1:0] blend_q16 = BLEND_RESET;
    node_result_t       trail_expect [$];
    coord_set_t         last_head;

    int fault_count = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_req    = 0;   // set by a test, taken up by the receiver process
    int hold_left   = 0;

    const string FIELD_NAME [COORDS] = '{"near_x", "near_y", "near_z",
                                         "far_x", "far_y", "far_z"};

    trail_follow_smoother #(
        .SEGMENTS (SEGMENTS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Run limit, far beyond the slowest correct run
    initial
    begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

    // ---------------------------------------------------------------------
    // Reporting
    // ---------------------------------------------------------------------
    task automatic report_fault(input string msg);
        if (fault_count < PRINT_CAP)
            $display("%0t ns: %s", $time, msg);
        fault_count++;
    endtask

    // ---------------------------------------------------------------------
    // Follower arithmetic: old + floor((dest - old) * w / 65536), kept to
    // 24 bits. The weight is at most 1.0, so the result never leaves the range.
    // ---------------------------------------------------------------------
    function automatic coord_t follow_coord(coord_t cur, coord_t dest, logic [BLEND_W-1:0] w);
        longint diff;
        longint prod;
        diff = longint'(dest) - longint'(cur);
        prod = diff * longint'(w);
        return coord_t'(longint'(cur) + (prod >>> FRAC_W));
    endfunction

    // Walk the chain for one accepted tick and queue the node results
    task automatic advance_trail(input coord_set_t head);
        coord_set_t   dest;
        node_result_t res;
        dest = head;
        for (int n = 0; n < NODES; n++)
        begin
            for (int c = 0; c < COORDS; c++)
            begin
                trail_pos[n][c] = follow_coord(trail_pos[n][c], dest[c], blend_q16);
                dest[c]         = trail_pos[n][c];
                res.coord[c]    = trail_pos[n][c];
            end
            res.node_index = IDX_W'(n);
            res.is_last    = (n == SEGMENTS);
            trail_expect.insert(trail_expect.size(), res);
        end
    endtask

    // ---------------------------------------------------------------------
    // Sender. tvalid stays high from one tick to the next unless a gap is
    // drawn, so it is never lowered and raised again within one step.
    // ---------------------------------------------------------------------
    task automatic offer_tick(input coord_set_t head);
        logic [S_TDATA_W-1:0] word;
        for (int c = 0; c < COORDS; c++)
            word[c*COORD_W +: COORD_W] = head[c];
        s_tdata  <= word;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        advance_trail(head);
        last_head = head;
        if ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < tx_idle_pct);
        end
    endtask

    task automatic offer_flat(input coord_t v);
        coord_set_t head;
        foreach (head[c])
            head[c] = v;
        offer_tick(head);
    endtask

    // Sender pauses until every expected result has come, plus a settle time
    task automatic drain_trail();
        s_tvalid <= 1'b0;
        while (trail_expect.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Weight write, only with the block idle
    task automatic set_blend(input logic [BLEND_W-1:0] w);
        drain_trail();
        cfg_wdata <= w;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        blend_q16 = (w > BLEND_ONE) ? BLEND_ONE : w;
    endtask

    // Mostly a random walk around the last head, some extremes and noise
    function automatic coord_t pick_coord(coord_t prev);
        int kind;
        kind = $urandom_range(9);
        case (kind)
            0: case ($urandom_range(3))
                   0: return coord_t'(24'h7FFFFF);
                   1: return coord_t'(24'h800000);
                   2: return coord_t'(0);
                   default: return coord_t'(-1);
               endcase
            1, 2: return coord_t'($urandom);
            default: return coord_t'(longint'(prev) + $signed($urandom_range(8192)) - 4096);
        endcase
    endfunction

    // ---------------------------------------------------------------------
    // Receiver: random stalls, or a counted hold-off when a test asks for one
    // ---------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_req != 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // ---------------------------------------------------------------------
    // Result checker: every master-side transfer against the oldest prediction
    // ---------------------------------------------------------------------
    always @(posedge clk)
    begin : check_results
        node_result_t want;
        coord_t       got;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (trail_expect.size() == 0)
                report_fault($sformatf("unexpected result, node_index %0d",
                                       m_tdata[IDX_W-1:0]));
            else
            begin
                want = trail_expect.pop_front();
                if (m_tdata[IDX_W-1:0] !== want.node_index)
                    report_fault($sformatf("node_index: got %0d, want %0d",
                                           m_tdata[IDX_W-1:0], want.node_index));
                for (int c = 0; c < COORDS; c++)
                begin
                    got = m_tdata[IDX_W + c*COORD_W +: COORD_W];
                    if (got !== want.coord[c])
                        report_fault($sformatf("node %0d %s: got %0d, want %0d",
                                               want.node_index, FIELD_NAME[c],
                                               got, want.coord[c]));
                end
                if (m_tlast !== want.is_last)
                    report_fault($sformatf("node %0d is_last: got %b, want %b",
                                           want.node_index, m_tlast, want.is_last));
            end
        end
    end

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // Reset weight (0.125) from a zero trail, full-scale and alternating bits
    task automatic test_reset_weight();
        coord_set_t head;
        offer_flat(coord_t'(24'h7FFFFF));
        offer_flat(coord_t'(24'h800000));
        head = '{coord_t'(24'h555555), coord_t'(24'hAAAAAA), coord_t'(0),
                 coord_t'(-1), coord_t'(24'h7FFFFF), coord_t'(24'h800000)};
        offer_tick(head);
    endtask

    // Weights above one clamp to 1.0: every node lands on its destination
    task automatic test_weight_clamp();
        set_blend(17'h1FFFF);
        offer_flat(coord_t'(24'h7FFFFF));
        offer_flat(coord_t'(24'h800000));
        set_blend(17'h10001);
        offer_flat(coord_t'(24'h7FFFFF));
        set_blend(BLEND_ONE);
        offer_flat(coord_t'(24'h800000));
    endtask

    // Zero weight holds the trail; the smallest weight shrinks a full-scale
    // pull to 1/65536 of it, floored
    task automatic test_weight_small();
        set_blend(17'h00000);
        offer_flat(coord_t'(24'h7FFFFF));
        offer_flat(coord_t'(0));
        set_blend(17'h00001);
        offer_flat(coord_t'(24'h7FFFFF));
        offer_flat(coord_t'(24'h800000));
    endtask

    // Half weight on odd differences: negative halves round towards minus
    // infinity
    task automatic test_floor_rounding();
        set_blend(17'h08000);
        offer_flat(coord_t'(1));
        offer_flat(coord_t'(-1));
        offer_flat(coord_t'(3));
        offer_flat(coord_t'(-3));
        offer_flat(coord_t'(0));
    endtask

    // Receiver holds off while the sender keeps offering: the block fills
    // and must stall its input without losing or repeating anything
    task automatic test_output_backpressure();
        coord_set_t head;
        set_blend(17'h04000);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req    = HOLD_CYCLES;
        repeat (6)
        begin
            foreach (head[c])
                head[c] = coord_t'($urandom);
            offer_tick(head);
        end
        drain_trail();
    endtask

    // Random ticks in two halves, each with its own weight
    task automatic test_random_phase(input int items, input int tx_pct, input int rx_pct);
        coord_set_t head;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int half = 0; half < 2; half++)
        begin
            case ($urandom_range(3))
                0: set_blend(BLEND_W'($urandom_range(17'h1FFFF)));
                1: set_blend(BLEND_W'($urandom_range(4095)));
                default: set_blend(BLEND_W'($urandom_range(BLEND_ONE, 1)));
            endcase
            repeat (items / 2)
            begin
                foreach (head[c])
                    head[c] = pick_coord(last_head[c]);
                offer_tick(head);
            end
        end
        drain_trail();
    endtask

    // ---------------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------------
    initial
    begin
        foreach (trail_pos[n, c])
            trail_pos[n][c] = '0;
        foreach (last_head[c])
            last_head[c] = '0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part runs with the sender idling and the receiver stalling
        tx_idle_pct = 37;
        rx_idle_pct = 64;
        test_reset_weight();
        test_weight_clamp();
        test_weight_small();
        test_floor_rounding();
        test_output_backpressure();

        test_random_phase(70, 37, 64);
        test_random_phase(70, 64, 37);
        test_random_phase(70, 0, 0);

        drain_trail();
        if (fault_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
